[rtl/lrf_pkg.sv]
`default_nettype none
package lrf_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  localparam int FUNC_W  = 2;
  localparam int COORD_W = 8;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 8;
  // error term width; Bresenham error stays within about +/- 2*255
  localparam int ACC_W   = 12;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch request fields, set up line terms
    logic wipe;      // write zero at sweep counter, advance it
    logic pix_rd;    // read byte under current pixel, latch address and mask
    logic pix_wr;    // write back byte with pixel bit set
    logic step;      // advance the line one pixel
    logic idx_rd;    // read byte at byte_index
    logic res_cap;   // capture read result
    logic out_load;  // move result into output register
  } lrf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic on_screen;
    logic at_end;
    logic wipe_last;
  } lrf_sts_t;

endpackage
`default_nettype wire

[rtl/lrf_if.sv]
`default_nettype none
interface lrf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] x_start;
  logic [7:0] y_start;
  logic [7:0] x_end;
  logic [7:0] y_end;
  logic [9:0] byte_index;

  modport source (output valid, func, x_start, y_start, x_end, y_end, byte_index,
                  input ready);
  modport sink (input valid, func, x_start, y_start, x_end, y_end, byte_index,
                output ready);
endinterface

interface lrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface
`default_nettype wire

[rtl/line_raster_framebuffer.sv]
// Sequence from accept to result: read latches the byte, then the result;
// unused code goes straight to the result; draw reads and writes back each
// on-screen pixel and steps past clipped ones; clear sweeps all STORE bytes.
// One request at a time; the final state waits while an earlier result is
// still not taken. Reset (rst_n low, synchronous): sweeps zeros over all STORE
// bytes, one byte a cycle; no request is accepted until the sweep ends.
`default_nettype none
module line_raster_framebuffer
  import lrf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lrf_in_if.sink    in_ch,
  lrf_out_if.source out_ch
);

  // Controller sequences the request; the datapath owns the store,
  // the line stepper and the output register.
  lrf_cmd_t cmd;
  lrf_sts_t sts;

  lrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The result register frees the input side: a new request can start while
  // the previous result still waits to be taken.
  lrf_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .x_start    (in_ch.x_start),
    .y_start    (in_ch.y_start),
    .x_end      (in_ch.x_end),
    .y_end      (in_ch.y_end),
    .byte_index (in_ch.byte_index),
    .read_data  (out_ch.read_data)
  );

endmodule
`default_nettype wire

[rtl/lrf_ctrl.sv]
`default_nettype none
module lrf_ctrl
  import lrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] in_func,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lrf_cmd_t               cmd,
  input  wire lrf_sts_t          sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIPE,
    ST_PIX,
    ST_WRITE,
    ST_RADDR,
    ST_RDATA,
    ST_RESP
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   wipe_reply_r;  // low for the post-reset sweep, high for a clear request
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.wipe     = (state_r == ST_WIPE);
    cmd.pix_rd   = (state_r == ST_PIX) && sts.on_screen;
    cmd.pix_wr   = (state_r == ST_WRITE);
    cmd.step     = ((state_r == ST_PIX) && !sts.on_screen && !sts.at_end) ||
                   ((state_r == ST_WRITE) && !sts.at_end);
    cmd.idx_rd   = (state_r == ST_RADDR);
    cmd.res_cap  = (state_r == ST_RDATA);
    cmd.out_load = (state_r == ST_RESP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WIPE;
      out_valid_r  <= 1'b0;
      wipe_reply_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (in_func)
              FUNC_CLEAR: begin
                state_r      <= ST_WIPE;
                wipe_reply_r <= 1'b1;
              end
              FUNC_DRAW: state_r <= ST_PIX;
              FUNC_READ: state_r <= ST_RADDR;
              default:   state_r <= ST_RESP;
            endcase
          end
        end
        ST_WIPE: begin
          if (sts.wipe_last) begin
            state_r <= wipe_reply_r ? ST_RESP : ST_IDLE;
          end
        end
        ST_PIX: begin
          if (sts.on_screen) begin
            state_r <= ST_WRITE;
          end else if (sts.at_end) begin
            state_r <= ST_RESP;
          end
        end
        ST_WRITE: begin
          state_r <= sts.at_end ? ST_RESP : ST_PIX;
        end
        ST_RADDR: state_r <= ST_RDATA;
        ST_RDATA: state_r <= ST_RESP;
        ST_RESP: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/lrf_dp.sv]
`default_nettype none
module lrf_dp
  import lrf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lrf_cmd_t           cmd,
  output lrf_sts_t                sts,
  input  wire logic [COORD_W-1:0] x_start,
  input  wire logic [COORD_W-1:0] y_start,
  input  wire logic [COORD_W-1:0] x_end,
  input  wire logic [COORD_W-1:0] y_end,
  input  wire logic [IDX_W-1:0]   byte_index,
  output logic [DATA_W-1:0]       read_data
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(STORE);

  logic [DATA_W-1:0] mem [STORE];

  logic [COORD_W-1:0]      xa_r, ya_r, xb_r, yb_r;
  logic signed [ACC_W-1:0] run_r, rise_r, acc_r;
  logic                    xinc_r, yinc_r;
  logic [IDX_W-1:0]        idx_r;
  logic [AW-1:0]           wipe_cnt_r;
  logic [AW-1:0]           pix_addr_r;
  logic [DATA_W-1:0]       pix_mask_r;
  logic [DATA_W-1:0]       q_r;
  logic [DATA_W-1:0]       res_r;
  logic [DATA_W-1:0]       out_data_r;

  logic [COORD_W-1:0]      dx_abs, dy_abs;
  logic signed [ACC_W:0]   twice, run_ext, rise_ext;
  logic                    move_x, move_y;
  logic signed [ACC_W-1:0] acc_nxt;
  logic [AW-1:0]           pix_addr, rd_addr;
  logic                    idx_ok;

  // setup terms
  assign dx_abs = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
  assign dy_abs = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);

  // Bresenham decision
  assign twice    = $signed({acc_r, 1'b0});
  assign run_ext  = $signed({run_r[ACC_W-1], run_r});
  assign rise_ext = $signed({rise_r[ACC_W-1], rise_r});
  assign move_x   = (twice >= rise_ext);
  assign move_y   = (twice <= run_ext);
  assign acc_nxt  = acc_r + (move_x ? rise_r : '0) + (move_y ? run_r : '0);

  assign sts.on_screen = ({1'b0, xa_r} < (COORD_W + 1)'(SCREEN_WIDTH)) &&
                         ({1'b0, ya_r} < (COORD_W + 1)'(SCREEN_HEIGHT));
  assign sts.at_end    = (xa_r == xb_r) && (ya_r == yb_r);
  assign sts.wipe_last = (wipe_cnt_r == AW'(STORE - 1));

  // column plus page times width; only used for on-screen pixels
  assign pix_addr = AW'(xa_r) + AW'(ya_r[COORD_W-1:3]) * AW'(SCREEN_WIDTH);
  assign idx_ok   = (32'(idx_r) < 32'(STORE));
  assign rd_addr  = cmd.pix_rd ? pix_addr : AW'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wipe_cnt_r <= '0;
    end else if (cmd.wipe) begin
      wipe_cnt_r <= sts.wipe_last ? '0 : wipe_cnt_r + 1'b1;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wipe) begin
      mem[wipe_cnt_r] <= '0;
    end else if (cmd.pix_wr) begin
      mem[pix_addr_r] <= q_r | pix_mask_r;
    end
    if (cmd.pix_rd || cmd.idx_rd) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      xa_r   <= x_start;
      ya_r   <= y_start;
      xb_r   <= x_end;
      yb_r   <= y_end;
      idx_r  <= byte_index;
      xinc_r <= (x_start < x_end);
      yinc_r <= (y_start < y_end);
      run_r  <= ACC_W'(dx_abs);
      rise_r <= -$signed(ACC_W'(dy_abs));
      acc_r  <= $signed(ACC_W'(dx_abs)) - $signed(ACC_W'(dy_abs));
      res_r  <= '0;
    end else begin
      if (cmd.step) begin
        acc_r <= acc_nxt;
        if (move_x) begin
          xa_r <= xinc_r ? xa_r + 1'b1 : xa_r - 1'b1;
        end
        if (move_y) begin
          ya_r <= yinc_r ? ya_r + 1'b1 : ya_r - 1'b1;
        end
      end
      if (cmd.res_cap) begin
        res_r <= idx_ok ? q_r : '0;
      end
    end
    if (cmd.pix_rd) begin
      pix_addr_r <= pix_addr;
      pix_mask_r <= DATA_W'(1) << ya_r[2:0];
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign read_data = out_data_r;

endmodule
`default_nettype wire

[rtl/lrf_checker.sv]
`default_nettype none
module lrf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("result dropped or changed while stalled");

  // one request in flight: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // a new result comes only as the block finishes a request
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result not aligned with end of request");

  // the store sweep follows reset
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready right after reset");

endmodule

bind line_raster_framebuffer lrf_checker u_lrf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data)
);
`default_nettype wire

[test/testbench.sv]
`default_nettype none
module testbench;
  import lrf_pkg::*;

  // Screen geometry matches the defaults the block is built with.
  localparam int SCR_W       = DEF_SCREEN_WIDTH;
  localparam int SCR_H       = DEF_SCREEN_HEIGHT;
  localparam int PAGES       = (SCR_H + 7) / 8;
  localparam int STORE_BYTES = SCR_W * PAGES;

  // func code 3 has no name in the package; the block must ignore it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Run shape. The random part stops after this many real requests.
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_AT      = 150;   // receiver goes dark here
  localparam int HOLD_CYCLES  = 1500;  // longer than a full clear
  localparam int PAUSE_AT     = 420;   // sender drains the block here
  localparam int STREAM_LO    = 280;   // no sender gaps in this window
  localparam int STREAM_HI    = 360;
  localparam int DRAIN_CYCLES = 64;
  // Worst case per request: a clear sweeps the whole store, a long line walks
  // every pixel, plus receiver stalls and sender gaps. Reset adds a sweep.
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [IDX_W-1:0]   idx;
  } fb_cmd_t;

  // Directed row: the request plus an optional hand-written expected byte.
  typedef struct packed {
    fb_cmd_t           cmd;
    logic              typed;
    logic [DATA_W-1:0] want;
  } fb_row_t;

  typedef enum logic [1:0] {
    SINK_OPEN,     // always ready
    SINK_RANDOM,   // ready with a chance of about three in four
    SINK_PATTERN   // fixed 16-bit ready pattern, repeated
  } sink_mode_t;

  // Directed part: corners, off-screen clipping, lines in six directions, unused code,
  // clear. Hand-typed results where they are obvious, predictor elsewhere.
  localparam int N_DIRECTED = 22;
  localparam fb_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // fresh store reads zero at both ends
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{FUNC_READ,   8'd255, 8'd255, 8'd255, 8'd255, 10'd1023}, 1'b1, 8'h00},
    // single pixel, top left corner -> byte 0 bit 0
    '{'{FUNC_DRAW,   8'd0,   8'd0,   8'd0,   8'd0,   10'd1023}, 1'b1, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h01},
    // single pixel, bottom right corner -> byte 1023 bit 7
    '{'{FUNC_DRAW,   8'd127, 8'd63,  8'd127, 8'd63,  10'd0},    1'b1, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd1023}, 1'b1, 8'h80},
    // unused code with every field bit set: no effect, zero back
    '{'{FUNC_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 10'd1023}, 1'b1, 8'h00},
    // single pixel fully off screen: nothing written
    '{'{FUNC_DRAW,   8'd255, 8'd255, 8'd255, 8'd255, 10'd0},    1'b1, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h01},
    // lines in six directions, some leaving the screen part way
    '{'{FUNC_DRAW,   8'd0,   8'd0,   8'd255, 8'd255, 10'd0},    1'b0, 8'h00},
    '{'{FUNC_DRAW,   8'd255, 8'd0,   8'd0,   8'd255, 10'd0},    1'b0, 8'h00},
    '{'{FUNC_DRAW,   8'd0,   8'd10,  8'd255, 8'd10,  10'd0},    1'b0, 8'h00},
    '{'{FUNC_DRAW,   8'd5,   8'd255, 8'd5,   8'd0,   10'd0},    1'b0, 8'h00},
    '{'{FUNC_DRAW,   8'd100, 8'd2,   8'd110, 8'd60,  10'd0},    1'b0, 8'h00},
    '{'{FUNC_DRAW,   8'd120, 8'd50,  8'd10,  8'd40,  10'd0},    1'b0, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd5},    1'b0, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd138},  1'b0, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd511},  1'b0, 8'h00},
    // clear wipes everything
    '{'{FUNC_CLEAR,  8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd1023}, 1'b1, 8'h00},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   10'd138},  1'b1, 8'h00}
  };

  logic clk;
  logic rst_n;

  lrf_in_if  in_ch ();
  lrf_out_if out_ch ();

  line_raster_framebuffer #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow framebuffer, same page/column layout as the block.
  logic [DATA_W-1:0] shadow_fb [STORE_BYTES];
  // Expected read_data for every request accepted but not yet answered.
  logic [DATA_W-1:0] pending_bytes [$];
  // Requests queued up by the random sequencer.
  fb_cmd_t           cmd_plan [$];

  int          err_count;
  int          cycle_count;
  int          func_count [4];
  int          lit_reads;
  bit          hold_req;
  sink_mode_t  sink_mode;
  logic [15:0] sink_pattern;
  logic [DATA_W-1:0] head_byte;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void plot_pixel(int x, int y);
    int pos;
    // clip: off-screen pixels are dropped, the line carries on
    if (x < 0 || y < 0 || x >= SCR_W || y >= SCR_H) return;
    pos = x + (y / 8) * SCR_W;
    if (pos < STORE_BYTES) shadow_fb[pos] |= DATA_W'(1 << (y % 8));
  endfunction

  // All-octant integer Bresenham, both endpoints included.
  function automatic void trace_line(int xa, int ya, int xb, int yb);
    int run, rise, stepx, stepy, acc, twice, guard;
    run   = (xb > xa) ? (xb - xa) : (xa - xb);
    rise  = (yb > ya) ? (ya - yb) : (yb - ya);   // kept negative
    stepx = (xa < xb) ? 1 : -1;
    stepy = (ya < yb) ? 1 : -1;
    acc   = run + rise;
    for (guard = 0; guard < 1024; guard++) begin
      plot_pixel(xa, ya);
      if (xa == xb && ya == yb) break;
      twice = 2 * acc;
      if (twice >= rise) begin
        acc += rise;
        xa  += stepx;
      end
      if (twice <= run) begin
        acc += run;
        ya  += stepy;
      end
    end
  endfunction

  // Apply one request to the shadow buffer, return its read_data.
  function automatic logic [DATA_W-1:0] apply_command(fb_cmd_t c);
    logic [DATA_W-1:0] data;
    data = '0;
    case (c.func)
      FUNC_CLEAR: begin
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
      end
      FUNC_DRAW: begin
        trace_line(int'(c.xs), int'(c.ys), int'(c.xe), int'(c.ye));
      end
      FUNC_READ: begin
        if (int'(c.idx) < STORE_BYTES) data = shadow_fb[c.idx];
      end
      default: begin
      end
    endcase
    return data;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_bytes.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result side: stall pattern plus one long hold-off on request
  // ---------------------------------------------------------------------

  initial begin
    int hold_left;
    int mode_left;
    hold_left    = 0;
    mode_left    = 0;
    sink_mode    = SINK_OPEN;
    sink_pattern = 16'b1011_0111_0010_1110;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        // long hold: block finishes its request, then backs up into input
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:    out_ch.ready <= 1'b1;
          SINK_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:      out_ch.ready <= sink_pattern[cycle_count % 16];
        endcase
      end
    end
  end

  // Results are sampled mid-cycle, where every handshake signal is settled;
  // valid and ready both high here means the result moves at the next edge.
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.read_data != '0) lit_reads++;
      if (pending_bytes.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: expected none, actual %02h",
                 $time, out_ch.read_data);
      end else begin
        head_byte = pending_bytes.pop_front();
        if (out_ch.read_data !== head_byte) begin
          err_count++;
          $display("%0t: read_data mismatch: expected %02h, actual %02h",
                   $time, head_byte, out_ch.read_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Present one request and hold it until taken. Ready is looked at mid-cycle;
  // the prediction is made there, the request moves at the next rising edge.
  // Valid is left high; the caller lowers it if a gap follows.
  task automatic issue(input fb_cmd_t c, input logic typed,
                       input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] predicted;
    in_ch.valid      <= 1'b1;
    in_ch.func       <= c.func;
    in_ch.x_start    <= c.xs;
    in_ch.y_start    <= c.ys;
    in_ch.x_end      <= c.xe;
    in_ch.y_end      <= c.ye;
    in_ch.byte_index <= c.idx;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    predicted = apply_command(c);
    pending_bytes.push_back(typed ? want : predicted);
    func_count[c.func]++;
    @(posedge clk);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic fb_cmd_t random_fields();
    fb_cmd_t c;
    c.func = FUNC_W'($urandom_range(0, 3));
    c.xs   = COORD_W'($urandom_range(0, 255));
    c.ys   = COORD_W'($urandom_range(0, 255));
    c.xe   = COORD_W'($urandom_range(0, 255));
    c.ye   = COORD_W'($urandom_range(0, 255));
    c.idx  = IDX_W'($urandom_range(0, 1023));
    return c;
  endfunction

  // mostly on screen, sometimes anywhere in the 8-bit range
  function automatic logic [COORD_W-1:0] pick_coord(input int span);
    if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, 255));
    return COORD_W'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(0, 16)) - 8;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return COORD_W'(n);
  endfunction

  // byte holding pixel (x, y); random byte when the pixel is clipped
  function automatic logic [IDX_W-1:0] byte_of(input int x, input int y);
    if (x < SCR_W && y < SCR_H) return IDX_W'(x + (y / 8) * SCR_W);
    return IDX_W'($urandom_range(0, 1023));
  endfunction

  // Queue the next random sequence. Most are a line followed by reads
  // of bytes it crosses, so reads come back with pixels set; the rest
  // are stray reads, clears and the unused code.
  task automatic plan_sequence();
    fb_cmd_t line, rd;
    int pick, n_reads, k;
    line = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      line.func = FUNC_CLEAR;
      cmd_plan.push_back(line);
    end else if (pick < 5) begin
      line.func = FUNC_UNUSED;
      cmd_plan.push_back(line);
    end else if (pick < 28) begin
      line.func = FUNC_READ;
      cmd_plan.push_back(line);
    end else begin
      line.func = FUNC_DRAW;
      line.xs   = pick_coord(SCR_W);
      line.ys   = pick_coord(SCR_H);
      if ($urandom_range(0, 2) == 0) begin
        // short line near the start point
        line.xe = nudge(line.xs);
        line.ye = nudge(line.ys);
      end else begin
        line.xe = pick_coord(SCR_W);
        line.ye = pick_coord(SCR_H);
      end
      cmd_plan.push_back(line);
      n_reads = $urandom_range(0, 3);
      for (k = 0; k < n_reads; k++) begin
        rd      = random_fields();
        rd.func = FUNC_READ;
        case (k)
          0:       rd.idx = byte_of(line.xs, line.ys);
          1:       rd.idx = byte_of(line.xe, line.ye);
          default: rd.idx = byte_of((int'(line.xs) + int'(line.xe)) / 2,
                                    (int'(line.ys) + int'(line.ye)) / 2);
        endcase
        cmd_plan.push_back(rd);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    fb_cmd_t c;
    int row, burst, gap, sent;
    bit hold_fired, pause_due, pause_done;

    err_count   = 0;
    cycle_count = 0;
    lit_reads   = 0;
    hold_req    = 1'b0;
    sent        = 0;
    hold_fired  = 1'b0;
    pause_due   = 1'b0;
    pause_done  = 1'b0;
    foreach (func_count[i]) func_count[i] = 0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_CLEAR;
    in_ch.x_start    = '0;
    in_ch.y_start    = '0;
    in_ch.x_end      = '0;
    in_ch.y_end      = '0;
    in_ch.byte_index = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // the block sweeps its store after reset; ready stays low meanwhile

    // directed part, small random gaps between rows
    for (row = 0; row < N_DIRECTED; row++) begin
      issue(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].typed,
            DIRECTED_ROWS[row].want);
      sender_gap(($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 6)) : 0);
    end

    // random part: bursts of requests with gaps between
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        if (cmd_plan.size() == 0) plan_sequence();
        c = cmd_plan.pop_front();
        issue(c, 1'b0, '0);
        if (c.func != FUNC_UNUSED) sent++;
        if (!hold_fired && sent >= HOLD_AT) begin
          hold_fired = 1'b1;
          hold_req   = 1'b1;   // sender keeps going into the hold
        end
        if (!pause_done && sent >= PAUSE_AT) pause_due = 1'b1;
      end
      if (pause_due && !pause_done) begin
        // stop offering until every result is back
        pause_done = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
      end else if (sent >= STREAM_LO && sent < STREAM_HI) begin
        gap = 0;   // back-to-back stretch
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
        sender_gap(gap);
      end
    end

    // drain, then give a stray result a chance to show up
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (out_ch.valid) begin
      err_count++;
      $display("%0t: unexpected result left on output: expected none, actual %02h",
               $time, out_ch.read_data);
    end

    $display("summary: %0d draws, %0d reads (%0d with pixels set), %0d clears,",
             func_count[FUNC_DRAW], func_count[FUNC_READ], lit_reads,
             func_count[FUNC_CLEAR]);
    $display("summary: %0d unused-code requests, %0d cycles, %0d mismatches",
             func_count[FUNC_UNUSED], cycle_count, err_count);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
